@@ src/bls_pkg.sv @@
// Shared constants, codes and helpers for the Bresenham line stepper.
// Used by the stepper top level and its port checker; no dependencies.
package bls_pkg;

    // Input field widths
    localparam int unsigned PIX_W    = 13;   // endpoint in whole pixels
    localparam int unsigned SCALE_W  = 5;    // supersample factor
    localparam int unsigned BUF_W    = 16;   // buffer width / height
    localparam int unsigned COORD_W  = 18;   // scaled coordinate, signed
    localparam int unsigned DIFF_W   = 19;   // difference of two coordinates
    localparam int unsigned DELTA_W  = 18;   // absolute delta, unsigned
    localparam int unsigned ERR_W    = 20;   // error accumulator, signed
    localparam int unsigned OUT_COORD_W = 17; // emitted sample coordinate

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = 56; // 4 x 13 bits, padded to bytes
    localparam int unsigned OUT_DATA_W = 40; // 2 x 17 bits, padded to bytes

    // Operation codes (carried in s_axis_tuser)
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_HEIGHT = 2'd2;

    // Configuration reset values
    localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd1;
    localparam logic [BUF_W-1:0]   WIDTH_RST  = 16'd1024;
    localparam logic [BUF_W-1:0]   HEIGHT_RST = 16'd1024;

    // Pixel coordinate times the supersample factor; the product always fits 18 bits
    function automatic logic signed [COORD_W-1:0] scale_coord(
        input logic signed [PIX_W-1:0] c,
        input logic [SCALE_W-1:0]      s
    );
        logic signed [COORD_W-1:0] c_ext;
        logic signed [COORD_W-1:0] s_ext;
        c_ext = COORD_W'(c);
        s_ext = $signed({{(COORD_W-SCALE_W){1'b0}}, s});
        return c_ext * s_ext;
    endfunction

    // Magnitude of a signed difference
    function automatic logic [DELTA_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? -d : d;
        return m[DELTA_W-1:0];
    endfunction

endpackage

@@ src/bresenham_line_stepper_unit.sv @@
// Bresenham line stepper top level: input register, start/step logic, result register.
// Depends on bls_pkg for widths, operation codes and register indexes.
//
// Usage:
//   s_axis carries requests. s_axis_tuser is the operation: start loads a new
//   line from the endpoints in s_axis_tdata, step asks for the next sample.
//   m_axis carries one sample per step while a line is active, with tlast on
//   the final sample and tuser set when the sample lies inside the buffer.
//   A start gives no result; a step with no active line gives nothing.
//   The cfg channel writes sample_scale, buffer_width and buffer_height; it is
//   always ready and is meant to be written while no request is in flight.
// Timing:
//   A request is registered on acceptance (scaling multiply happens at the
//   input); when it advances it updates the line state and loads the result
//   register, so a step's sample passes the input register and then the result
//   register before it is valid on m_axis.
//   One request per cycle is sustained while m_axis_tready is high; the line state
//   update (one add, one compare and one subtract on the error term) is the per-cycle loop.
// Reset and stalls:
//   Synchronous active-low reset empties both registers, ends any line and
//   restores the configuration defaults. While m_axis_tready is low a result
//   holds; the input register still takes one more request, and further
//   step requests wait until the result is taken.
module bresenham_line_stepper_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [12:0] start_x, [25:13] start_y, [38:26] end_x, [51:39] end_y, [55:52] zero
    input  logic [bls_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [0] operation
    input  logic                                 s_axis_tuser,
    // sample stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] sample_x, [33:17] sample_y, [39:34] zero
    output logic [bls_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] inside_res
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bls_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bls_pkg::BUF_W-1:0]            i_cfg_data
);

    localparam int unsigned CW = bls_pkg::COORD_W;
    localparam int unsigned DW = bls_pkg::DIFF_W;
    localparam int unsigned EW = bls_pkg::ERR_W;
    localparam int unsigned MW = bls_pkg::DELTA_W;
    localparam int unsigned SW = bls_pkg::OUT_COORD_W;
    localparam int unsigned PW = bls_pkg::PIX_W;

    // Configuration registers
    logic [bls_pkg::SCALE_W-1:0] r_scale;
    logic [bls_pkg::BUF_W-1:0]   r_buf_w;
    logic [bls_pkg::BUF_W-1:0]   r_buf_h;

    // Input register (scaled endpoints)
    logic                 r_in_valid;
    logic                 r_in_op;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;

    // Line state
    logic                 r_active;
    logic                 r_swapped;
    logic                 r_minor_down;
    logic signed [CW-1:0] r_major_pos, r_major_end, r_minor_pos;
    logic [MW-1:0]        r_major_delta, r_minor_delta;
    logic signed [EW-1:0] r_err;

    // Result register
    logic                 r_out_valid;
    logic [SW-1:0]        r_out_x, r_out_y;
    logic                 r_out_inside, r_out_last;

    // Handshake
    logic in_accept, cfg_accept, advance, produce, out_free;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid & o_cfg_ready;

    assign produce       = (r_in_op == bls_pkg::OP_STEP) & r_active;
    assign out_free      = ~r_out_valid | m_axis_tready;
    assign advance       = r_in_valid & (~produce | out_free);
    assign s_axis_tready = ~r_in_valid | advance;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= bls_pkg::SCALE_RST;
            r_buf_w <= bls_pkg::WIDTH_RST;
            r_buf_h <= bls_pkg::HEIGHT_RST;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                bls_pkg::CFG_SAMPLE_SCALE:  r_scale <= i_cfg_data[bls_pkg::SCALE_W-1:0];
                bls_pkg::CFG_BUFFER_WIDTH:  r_buf_w <= i_cfg_data;
                bls_pkg::CFG_BUFFER_HEIGHT: r_buf_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: scale endpoints as the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op <= s_axis_tuser;
            r_x0    <= bls_pkg::scale_coord(s_axis_tdata[PW-1:0], r_scale);
            r_y0    <= bls_pkg::scale_coord(s_axis_tdata[2*PW-1:PW], r_scale);
            r_x1    <= bls_pkg::scale_coord(s_axis_tdata[3*PW-1:2*PW], r_scale);
            r_y1    <= bls_pkg::scale_coord(s_axis_tdata[4*PW-1:3*PW], r_scale);
        end
    end

    // Start: pick the major axis, order endpoints, derive deltas
    logic signed [DW-1:0] dx, dy, db;
    logic [MW-1:0]        adx, ady;
    logic                 steep, reorder;
    logic signed [CW-1:0] a0, b0, a1, b1, sa0, sb0, sa1, sb1;
    logic signed [DW-1:0] da;

    always_comb begin
        dx    = DW'(r_x1) - DW'(r_x0);
        dy    = DW'(r_y1) - DW'(r_y0);
        adx   = bls_pkg::abs_diff(dx);
        ady   = bls_pkg::abs_diff(dy);
        steep = adx < ady;
        a0    = steep ? r_y0 : r_x0;
        b0    = steep ? r_x0 : r_y0;
        a1    = steep ? r_y1 : r_x1;
        b1    = steep ? r_x1 : r_y1;
        reorder = a0 > a1;
        sa0   = reorder ? a1 : a0;
        sb0   = reorder ? b1 : b0;
        sa1   = reorder ? a0 : a1;
        sb1   = reorder ? b0 : b1;
        db    = DW'(sb1) - DW'(sb0);
        da    = DW'(sa1) - DW'(sa0);
    end

    // Step: emit current sample, advance the error term
    logic signed [CW-1:0]   cur_x, cur_y;
    logic                   is_last, in_bounds;
    logic signed [EW:0]     err_add;
    logic signed [EW+1:0]   err_twice;
    logic                   minor_step;
    logic signed [EW:0]     err_sub;

    always_comb begin
        cur_x   = r_swapped ? r_minor_pos : r_major_pos;
        cur_y   = r_swapped ? r_major_pos : r_minor_pos;
        is_last = r_major_pos == r_major_end;
        in_bounds = ~cur_x[CW-1] & (cur_x[CW-2:0] < {1'b0, r_buf_w})
                  & ~cur_y[CW-1] & (cur_y[CW-2:0] < {1'b0, r_buf_h});
        err_add    = (EW+1)'(r_err) + $signed({1'b0, (EW)'(r_minor_delta)});
        err_twice  = {err_add, 1'b0};
        minor_step = err_twice >= $signed({(EW+2-MW)'(0), r_major_delta});
        err_sub    = err_add - $signed({1'b0, (EW)'(r_major_delta)});
    end

    // Line state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_swapped     <= 1'b0;
            r_minor_down  <= 1'b0;
            r_major_pos   <= '0;
            r_major_end   <= '0;
            r_minor_pos   <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_err         <= '0;
        end else if (advance) begin
            if (r_in_op == bls_pkg::OP_START) begin
                r_active      <= 1'b1;
                r_swapped     <= steep;
                r_minor_down  <= db[DW-1] | (db == '0);
                r_major_pos   <= sa0;
                r_major_end   <= sa1;
                r_minor_pos   <= sb0;
                r_major_delta <= da[MW-1:0];
                r_minor_delta <= bls_pkg::abs_diff(db);
                r_err         <= '0;
            end else if (r_active) begin
                if (is_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_major_pos <= r_major_pos + CW'(1);
                    if (minor_step) begin
                        r_minor_pos <= r_minor_down ? r_minor_pos - CW'(1)
                                                    : r_minor_pos + CW'(1);
                        r_err       <= err_sub[EW-1:0];
                    end else begin
                        r_err       <= err_add[EW-1:0];
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_out_x      <= cur_x[SW-1:0];
            r_out_y      <= cur_y[SW-1:0];
            r_out_inside <= in_bounds;
            r_out_last   <= is_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(bls_pkg::OUT_DATA_W-2*SW)'(0), r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_inside;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ src/bls_checker.sv @@
// Port-level checker for the Bresenham line stepper, bound to the top level.
// Depends on bls_pkg for payload widths.
module bls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bls_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);

    localparam int unsigned SW = bls_pkg::OUT_COORD_W;

    // A stalled sample holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("sample changed while stalled");

    // Reset leaves no sample pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("sample valid right after reset");

    // An inside sample never has a negative coordinate
    a_inside_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[SW-1] && !m_axis_tdata[2*SW-1])
        else $error("inside flag on negative coordinate");

    // A sample from an empty output comes from a request taken earlier, through the input and result registers
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("sample without a matching request");

endmodule

bind bresenham_line_stepper_unit bls_checker u_bls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
